@@ design/ptq_pkg.sv @@
// Shared constants and types for the periodic task timer queue.
package ptq_pkg;

  // Default queue depth in tasks
  localparam int unsigned MaxTasksDef = 8;

  // Field widths fixed by the request and result formats
  localparam int unsigned PeriodW = 16;
  localparam int unsigned ScaledW = 20;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PrioW   = 2;
  localparam int unsigned IdOutW  = 3;

  // Result of one request
  typedef struct packed {
    logic              status;
    logic [IdOutW-1:0] new_task_id;
    logic              fired;
    logic [IdOutW-1:0] fired_task_id;
    logic [PrioW-1:0]  fired_priority;
  } result_t;

  // Outputs of the shared arithmetic unit
  typedef struct packed {
    logic [TimeW-1:0] sum;
    logic             lt;
  } alu_res_t;

endpackage

@@ design/ptq_req_if.sv @@
// Request channel of the periodic task timer queue.
interface ptq_req_if;
  import ptq_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [PeriodW-1:0] period;
  logic [PrioW-1:0]   priority_req;

  modport source (output valid, output action, output period, output priority_req,
                  input ready);
  modport sink   (input valid, input action, input period, input priority_req,
                  output ready);
endinterface

@@ design/ptq_rsp_if.sv @@
// Result channel of the periodic task timer queue.
interface ptq_rsp_if;
  import ptq_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [IdOutW-1:0] new_task_id;
  logic              fired;
  logic [IdOutW-1:0] fired_task_id;
  logic [PrioW-1:0]  fired_priority;

  modport source (output valid, output status, output new_task_id, output fired,
                  output fired_task_id, output fired_priority, input ready);
  modport sink   (input valid, input status, input new_task_id, input fired,
                  input fired_task_id, input fired_priority, output ready);
endinterface

@@ design/periodic_task_timer_queue_top.sv @@
// Periodic task timer queue: sorted due-time queue walked by a small sequencer.
// A full queue refuses an add. An add walks from the tail and shifts later entries back to make room;
//   a tick advances the counter and, when the head is due, fires it and walks it back to its new place.
//   Each entry passed takes a read state and then a compare-and-write state of the queue memory walk.
//   One request at a time.
// The next request can be taken as soon as result valid rises. Reset clears control and tick count only.
module periodic_task_timer_queue_top #(
  parameter int unsigned MAX_TASKS = ptq_pkg::MaxTasksDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  ptq_req_if.sink    req_i,
  ptq_rsp_if.source  rsp_o
);
  import ptq_pkg::*;

  localparam int unsigned IdW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SCALE = 10'b00_0000_0010,
    S_TICK  = 10'b00_0000_0100,
    S_HEAD  = 10'b00_0000_1000,
    S_BUMP  = 10'b00_0001_0000,
    S_ARD   = 10'b00_0010_0000,
    S_ACMP  = 10'b00_0100_0000,
    S_FRD   = 10'b00_1000_0000,
    S_FCMP  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [TimeW-1:0]    tick_q, tick_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     k_q, k_d;
  logic [CntW-1:0]     km1;
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  result_t             res_q, res_d;
  result_t             out_q;

  // Latched request payload
  logic                action_q;
  logic [PeriodW-1:0]  period_q;
  logic [PrioW-1:0]    prio_q;
  logic                in_acc;

  // Task being placed
  logic [TimeW-1:0]    cur_due_q, cur_due_d;
  logic [ScaledW-1:0]  cur_per_q, cur_per_d;
  logic [PrioW-1:0]    cur_pri_q, cur_pri_d;
  logic [IdW-1:0]      cur_id_q, cur_id_d;

  // Queue memory, ordered by due time, one entry per position
  logic [TimeW-1:0]    mem_due [MAX_TASKS];
  logic [ScaledW-1:0]  mem_per [MAX_TASKS];
  logic [PrioW-1:0]    mem_pri [MAX_TASKS];
  logic [IdW-1:0]      mem_id  [MAX_TASKS];
  logic [TimeW-1:0]    rd_due_q;
  logic [ScaledW-1:0]  rd_per_q;
  logic [PrioW-1:0]    rd_pri_q;
  logic [IdW-1:0]      rd_id_q;
  logic [IdW-1:0]      raddr, waddr;
  logic                we, wsel_cur;

  logic [IdW+2:0]      cur_id_ext, rd_id_ext;

  logic [TimeW-1:0]    alu_a, alu_b;
  alu_res_t            alu;

  ptq_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign km1         = k_q - CntW'(1);
  assign cur_id_ext  = {3'b000, cur_id_q};
  assign rd_id_ext   = {3'b000, rd_id_q};

  // Sequencer
  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    res_d     = res_q;
    cur_due_d = cur_due_q;
    cur_per_d = cur_per_q;
    cur_pri_d = cur_pri_q;
    cur_id_d  = cur_id_q;
    alu_a     = '0;
    alu_b     = '0;
    raddr     = '0;
    waddr     = '0;
    we        = 1'b0;
    wsel_cur  = 1'b1;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          if (req_i.action && (cnt_q == CntW'(MAX_TASKS))) begin
            res_d.status = 1'b1;
            state_d      = S_DONE;
          end else if (req_i.action) begin
            state_d = S_SCALE;
          end else begin
            state_d = S_TICK;
          end
        end
      end
      // Scale the period by ten as 8p + 2p
      S_SCALE: begin
        alu_a     = TimeW'({period_q, 3'b000});
        alu_b     = TimeW'({period_q, 1'b0});
        cur_per_d = alu.sum[ScaledW-1:0];
        cur_due_d = TimeW'(alu.sum[ScaledW-1:0]);
        cur_pri_d = prio_q;
        cur_id_d  = cnt_q[IdW-1:0];
        k_d       = cnt_q;
        state_d   = S_ARD;
      end
      // Add: walk from the tail, read the entry in front of the hole
      S_ARD: begin
        if (k_q == '0) begin
          we                = 1'b1;
          waddr             = '0;
          res_d.new_task_id = cur_id_ext[2:0];
          cnt_d             = cnt_q + CntW'(1);
          state_d           = S_DONE;
        end else begin
          raddr   = km1[IdW-1:0];
          state_d = S_ACMP;
        end
      end
      // Add: shift entries not strictly earlier, else drop the task into the hole
      S_ACMP: begin
        alu_a = rd_due_q;
        alu_b = cur_due_q;
        we    = 1'b1;
        waddr = k_q[IdW-1:0];
        if (!alu.lt) begin
          wsel_cur = 1'b0;
          k_d      = km1;
          state_d  = S_ARD;
        end else begin
          res_d.new_task_id = cur_id_ext[2:0];
          cnt_d             = cnt_q + CntW'(1);
          state_d           = S_DONE;
        end
      end
      // Tick: advance the counter, fetch the head
      S_TICK: begin
        alu_a  = tick_q;
        alu_b  = TimeW'(1);
        tick_d = alu.sum;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          raddr   = '0;
          state_d = S_HEAD;
        end
      end
      // Fire when the head is due strictly before the counter
      S_HEAD: begin
        alu_a = rd_due_q;
        alu_b = tick_q;
        if (alu.lt) begin
          cur_due_d            = rd_due_q;
          cur_per_d            = rd_per_q;
          cur_pri_d            = rd_pri_q;
          cur_id_d             = rd_id_q;
          res_d.fired          = 1'b1;
          res_d.fired_task_id  = rd_id_ext[2:0];
          res_d.fired_priority = rd_pri_q;
          state_d              = S_BUMP;
        end else begin
          state_d = S_DONE;
        end
      end
      // Advance the fired task's due time by its period
      S_BUMP: begin
        alu_a     = cur_due_q;
        alu_b     = TimeW'(cur_per_q);
        cur_due_d = alu.sum;
        k_d       = CntW'(1);
        state_d   = S_FRD;
      end
      // Reinsert: read the next entry or place the task at the tail
      S_FRD: begin
        if (k_q == cnt_q) begin
          we      = 1'b1;
          waddr   = km1[IdW-1:0];
          state_d = S_DONE;
        end else begin
          raddr   = k_q[IdW-1:0];
          state_d = S_FCMP;
        end
      end
      // Reinsert: move strictly earlier entries forward, else place the task
      S_FCMP: begin
        alu_a = rd_due_q;
        alu_b = cur_due_q;
        we    = 1'b1;
        waddr = km1[IdW-1:0];
        if (alu.lt) begin
          wsel_cur = 1'b0;
          k_d      = k_q + CntW'(1);
          state_d  = S_FRD;
        end else begin
          state_d = S_DONE;
        end
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= req_i.action;
      period_q <= req_i.period;
      prio_q   <= req_i.priority_req;
    end
    res_q     <= res_d;
    cur_due_q <= cur_due_d;
    cur_per_q <= cur_per_d;
    cur_pri_q <= cur_pri_d;
    cur_id_q  <= cur_id_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Queue memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_due[waddr] <= wsel_cur ? cur_due_q : rd_due_q;
      mem_per[waddr] <= wsel_cur ? cur_per_q : rd_per_q;
      mem_pri[waddr] <= wsel_cur ? cur_pri_q : rd_pri_q;
      mem_id[waddr]  <= wsel_cur ? cur_id_q  : rd_id_q;
    end
    rd_due_q <= mem_due[raddr];
    rd_per_q <= mem_per[raddr];
    rd_pri_q <= mem_pri[raddr];
    rd_id_q  <= mem_id[raddr];
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.new_task_id    = out_q.new_task_id;
  assign rsp_o.fired          = out_q.fired;
  assign rsp_o.fired_task_id  = out_q.fired_task_id;
  assign rsp_o.fired_priority = out_q.fired_priority;

  // Task count never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_TASKS))
    else $error("task count above queue depth");

  // A refused add is reported only with a full queue
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (cnt_q == CntW'(MAX_TASKS)))
    else $error("full status with free queue slots");

  // A fire is reported only with tasks in the queue
  a_fire_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.fired) |-> (cnt_q != '0))
    else $error("fire reported from an empty queue");

  // An accepted tick advances the counter by one
  a_tick_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !req_i.action) |-> ##2 (tick_q == TimeW'($past(tick_q, 2) + TimeW'(1))))
    else $error("tick counter did not advance");

  // The latched action selects the add or the tick path
  a_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCALE) |-> action_q)
    else $error("add path entered on a tick request");

endmodule

@@ design/ptq_alu.sv @@
// Shared 32-bit adder and unsigned less-than compare of the timer queue.
module ptq_alu (
  input  logic [ptq_pkg::TimeW-1:0] a_i,
  input  logic [ptq_pkg::TimeW-1:0] b_i,
  output ptq_pkg::alu_res_t         res_o
);
  import ptq_pkg::*;

  // Add modulo 2^32 and compare a below b
  always_comb begin
    res_o.sum = a_i + b_i;
    res_o.lt  = (a_i < b_i);
  end

endmodule
